// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the sine/cosine unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every edge outside reset
`define SCP_ASSERT_HOLDS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// cons must hold in the cycle where ante holds
`define SCP_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/sincos_pkg.sv =====
// ----------------------------------------------------------------------------
// sincos_pkg
// Types and constants shared by the sine/cosine pipeline.
// ----------------------------------------------------------------------------
package sincos_pkg;

    localparam int ANGLE_W = 32;
    localparam int OUT_W   = 18;

    // remainder in 32 fraction bits, polynomial argument in 30
    localparam int RW  = 36;
    localparam int XW  = RW - 2;
    localparam int SQW = 35;
    localparam int P1W = 26;
    localparam int P2W = 32;
    localparam int P3W = 33;
    localparam int YW  = 34;
    localparam int CW  = 32;
    localparam int POLY_SH = 30;

    localparam logic [31:0] TWO_OVER_PI_Q32 = 32'd2734261102;
    localparam logic [7:0]  HALF_PI_RAT     = 8'd201;
    localparam int          HALF_PI_RAT_SH  = 25;
    localparam logic [20:0] HALF_PI_RES     = 21'd2078020;
    localparam logic signed [RW-1:0] HALF_PI_Q32 = 36'sd6746518852;

    localparam logic signed [CW-1:0] POLY_ONE = 32'sd1073741824;
    localparam logic signed [CW-1:0] POLY_C3  = 32'sd178949812;
    localparam logic signed [CW-1:0] POLY_C5  = 32'sd8927412;
    localparam logic signed [CW-1:0] POLY_C7  = 32'sd199093;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd131071;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd131072;

    typedef enum logic [1:0] {
        QUAD_I,
        QUAD_II,
        QUAD_III,
        QUAD_IV
    } quad_t;

    typedef struct packed {
        logic                 neg;
        logic signed [XW-1:0] x_sin;
        logic signed [XW-1:0] x_cos;
    } x_pair_t;

    typedef struct packed {
        logic                 neg;
        logic signed [YW-1:0] y_sin;
        logic signed [YW-1:0] y_cos;
    } y_pair_t;

endpackage

// ===== hw/rtl/sincos_reduce.sv =====
// ----------------------------------------------------------------------------
// sincos_reduce
// Sign removal, quadrant count by 2/pi, exact remainder and per-quadrant arguments, five stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sincos_reduce #(
    parameter int ANGLE_FRAC_BITS = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [sincos_pkg::ANGLE_W-1:0] in_angle,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output sincos_pkg::x_pair_t                   out_data
);
    import sincos_pkg::*;

    localparam int QW  = 32 - ANGLE_FRAC_BITS;
    localparam int MSH = 32 - ANGLE_FRAC_BITS;
    localparam int MW  = 32 + MSH;
    localparam int PW  = RW + QW;
    localparam int NS  = 5;

    logic [NS-1:0] vld_reg, vld_next, en;

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NS; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    // stage A: magnitude
    logic        neg_a_reg;
    logic [31:0] mag_a_reg, mag_a_next;

    assign mag_a_next = in_angle[ANGLE_W-1] ? unsigned'(-in_angle) : unsigned'(in_angle);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            neg_a_reg <= in_angle[ANGLE_W-1];
            mag_a_reg <= mag_a_next;
        end
    end

    // stage B: quadrant count
    logic [63:0]   prod_b;
    logic          neg_b_reg;
    logic [31:0]   mag_b_reg;
    logic [QW-1:0] q_b_reg, q_b_next;

    assign prod_b   = 64'(mag_a_reg) * 64'(TWO_OVER_PI_Q32);
    assign q_b_next = prod_b[63 -: QW];

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            neg_b_reg <= neg_a_reg;
            mag_b_reg <= mag_a_reg;
            q_b_reg   <= q_b_next;
        end
    end

    // stage C: multiples of pi/2, kept modulo 2^RW
    logic [MW-1:0] m32_full;
    logic [PW-1:0] rat_full, res_full;
    logic [RW-1:0] m32_c_reg, rat_c_reg, res_c_reg;
    logic [RW-1:0] m32_c_next, rat_c_next, res_c_next;
    logic [1:0]    quad_c_reg;
    logic          neg_c_reg;

    assign m32_full   = {mag_b_reg, {MSH{1'b0}}};
    assign rat_full   = PW'(q_b_reg) * PW'(HALF_PI_RAT);
    assign res_full   = PW'(q_b_reg) * PW'(HALF_PI_RES);
    assign m32_c_next = m32_full[RW-1:0];
    assign rat_c_next = rat_full[RW-1:0] << HALF_PI_RAT_SH;
    assign res_c_next = res_full[RW-1:0];

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            m32_c_reg  <= m32_c_next;
            rat_c_reg  <= rat_c_next;
            res_c_reg  <= res_c_next;
            quad_c_reg <= q_b_reg[1:0];
            neg_c_reg  <= neg_b_reg;
        end
    end

    // stage D: remainder
    logic signed [RW-1:0] r_d_reg, r_d_next;
    logic [1:0]           quad_d_reg;
    logic                 neg_d_reg;

    assign r_d_next = signed'(m32_c_reg - rat_c_reg - res_c_reg);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            r_d_reg    <= r_d_next;
            quad_d_reg <= quad_c_reg;
            neg_d_reg  <= neg_c_reg;
        end
    end

    // stage E: per-quadrant arguments
    logic signed [RW-1:0] rm_e, xs32, xc32;
    logic signed [XW-1:0] xs_e_reg, xc_e_reg;
    logic                 neg_e_reg;

    assign rm_e = r_d_reg - HALF_PI_Q32;

    always_comb begin
        unique case (quad_t'(quad_d_reg))
            QUAD_I: begin
                xs32 = r_d_reg;
                xc32 = -rm_e;
            end
            QUAD_II: begin
                xs32 = -rm_e;
                xc32 = -r_d_reg;
            end
            QUAD_III: begin
                xs32 = -r_d_reg;
                xc32 = rm_e;
            end
            default: begin
                xs32 = rm_e;
                xc32 = r_d_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            xs_e_reg  <= xs32[RW-1:2];
            xc_e_reg  <= xc32[RW-1:2];
            neg_e_reg <= neg_d_reg;
        end
    end

    assign out_data.neg   = neg_e_reg;
    assign out_data.x_sin = xs_e_reg;
    assign out_data.x_cos = xc_e_reg;

    `SCP_ASSERT_HOLDS(a_rem_nonneg, aclk, aresetn, !vld_reg[3] || !r_d_reg[RW-1])

endmodule

// ===== hw/rtl/sincos_poly.sv =====
// ----------------------------------------------------------------------------
// sincos_poly
// Degree-7 odd polynomial by Horner's rule in x^2, two lanes, five stages.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sincos_poly (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  sincos_pkg::x_pair_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output sincos_pkg::y_pair_t out_data
);
    import sincos_pkg::*;

    localparam int NS = 5;
    localparam int NL = 2;
    localparam int LANE_SIN = 0;
    localparam int LANE_COS = 1;

    logic [NS-1:0] vld_reg, vld_next, en;

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--) begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_next[0] = en[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NS; i++) begin
            vld_next[i] = en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NS-1];

    logic signed [XW-1:0] x_in [NL];

    assign x_in[LANE_SIN] = in_data.x_sin;
    assign x_in[LANE_COS] = in_data.x_cos;

    logic [NS-1:0] neg_reg;

    logic signed [2*XW-1:0]    sq_prod [NL];
    logic signed [SQW+CW-1:0]  t_prod  [NL];
    logic signed [SQW+P1W-1:0] a_prod  [NL];
    logic signed [SQW+P2W-1:0] b_prod  [NL];
    logic signed [XW+P3W-1:0]  y_prod  [NL];

    logic signed [XW-1:0]  x_s1_reg [NL], x_s2_reg [NL], x_s3_reg [NL], x_s4_reg [NL];
    logic signed [SQW-1:0] sq_s1_reg [NL], sq_s2_reg [NL], sq_s3_reg [NL];
    logic signed [P1W-1:0] p1_s2_reg [NL];
    logic signed [P2W-1:0] p2_s3_reg [NL];
    logic signed [P3W-1:0] p3_s4_reg [NL];
    logic signed [YW-1:0]  y_s5_reg [NL];

    logic signed [SQW-1:0] sq_next [NL];
    logic signed [P1W-1:0] p1_next [NL];
    logic signed [P2W-1:0] p2_next [NL];
    logic signed [P3W-1:0] p3_next [NL];
    logic signed [YW-1:0]  y_next  [NL];

    always_comb begin
        for (int l = 0; l < NL; l++) begin
            sq_prod[l] = x_in[l] * x_in[l];
            sq_next[l] = SQW'(sq_prod[l] >>> POLY_SH);
            t_prod[l]  = sq_s1_reg[l] * POLY_C7;
            p1_next[l] = P1W'(POLY_C5 - (t_prod[l] >>> POLY_SH));
            a_prod[l]  = sq_s2_reg[l] * p1_s2_reg[l];
            p2_next[l] = P2W'((a_prod[l] >>> POLY_SH) - POLY_C3);
            b_prod[l]  = sq_s3_reg[l] * p2_s3_reg[l];
            p3_next[l] = P3W'((b_prod[l] >>> POLY_SH) + POLY_ONE);
            y_prod[l]  = x_s4_reg[l] * p3_s4_reg[l];
            y_next[l]  = YW'(y_prod[l] >>> POLY_SH);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            neg_reg[0] <= in_data.neg;
        end
        for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
                neg_reg[i] <= neg_reg[i-1];
            end
        end
        for (int l = 0; l < NL; l++) begin
            if (en[0]) begin
                x_s1_reg[l]  <= x_in[l];
                sq_s1_reg[l] <= sq_next[l];
            end
            if (en[1]) begin
                x_s2_reg[l]  <= x_s1_reg[l];
                sq_s2_reg[l] <= sq_s1_reg[l];
                p1_s2_reg[l] <= p1_next[l];
            end
            if (en[2]) begin
                x_s3_reg[l]  <= x_s2_reg[l];
                sq_s3_reg[l] <= sq_s2_reg[l];
                p2_s3_reg[l] <= p2_next[l];
            end
            if (en[3]) begin
                x_s4_reg[l]  <= x_s3_reg[l];
                p3_s4_reg[l] <= p3_next[l];
            end
            if (en[4]) begin
                y_s5_reg[l] <= y_next[l];
            end
        end
    end

    assign out_data.neg   = neg_reg[NS-1];
    assign out_data.y_sin = y_s5_reg[LANE_SIN];
    assign out_data.y_cos = y_s5_reg[LANE_COS];

    `SCP_ASSERT_IMPL(a_sq_nonneg, aclk, aresetn, vld_reg[0], !sq_s1_reg[LANE_SIN][SQW-1] && !sq_s1_reg[LANE_COS][SQW-1])
    `SCP_ASSERT_IMPL(a_p3_bound, aclk, aresetn, vld_reg[3], (p3_s4_reg[LANE_SIN] <= P3W'(POLY_ONE)) && (p3_s4_reg[LANE_COS] <= P3W'(POLY_ONE)))

endmodule

// ===== hw/rtl/sincos_round.sv =====
// ----------------------------------------------------------------------------
// sincos_round
// Round half up, sine sign restore and saturation into the output register.
// ----------------------------------------------------------------------------
module sincos_round #(
    parameter int OUT_FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sincos_pkg::y_pair_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sincos_pkg::OUT_W-1:0] out_sine,
    output logic signed [sincos_pkg::OUT_W-1:0] out_cosine
);
    import sincos_pkg::*;

    localparam int SH = POLY_SH - OUT_FRAC_BITS;
    localparam int VW = YW + 2;
    localparam logic signed [YW:0] HALF = ((YW+1)'(1) << SH) >>> 1;

    logic                    vld_reg, en;
    logic signed [YW:0]      sum_s, sum_c;
    logic signed [VW-1:0]    vs, vc;
    logic signed [OUT_W-1:0] sine_reg, sine_next, cosine_reg, cosine_next;

    assign en       = !vld_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        sum_s = (YW+1)'(in_data.y_sin) + HALF;
        sum_c = (YW+1)'(in_data.y_cos) + HALF;
        vs    = in_data.neg ? -VW'(sum_s >>> SH) : VW'(sum_s >>> SH);
        vc    = VW'(sum_c >>> SH);
        priority if (vs > OUT_MAX) begin
            sine_next = OUT_MAX;
        end else if (vs < OUT_MIN) begin
            sine_next = OUT_MIN;
        end else begin
            sine_next = vs[OUT_W-1:0];
        end
        priority if (vc > OUT_MAX) begin
            cosine_next = OUT_MAX;
        end else if (vc < OUT_MIN) begin
            cosine_next = OUT_MIN;
        end else begin
            cosine_next = vc[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

    assign out_valid  = vld_reg;
    assign out_sine   = sine_reg;
    assign out_cosine = cosine_reg;

endmodule

// ===== hw/rtl/sin_cos_polynomial_unit_core.sv =====
// Stages from input item to result item: 5 reduction, 5 polynomial, 1 output.
// Throughput: one item per cycle while m_ready is high; set by the multiplier stages.
// Stalls hold each stage in place; empty stages still fill while the output waits.
// Reset (aresetn low, synchronous) clears all stage valid bits; data registers keep contents.
// ----------------------------------------------------------------------------
// sin_cos_polynomial_unit_core
// Pipelined sine and cosine of a Q7.24 angle, Q1.16 results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sin_cos_polynomial_unit_core #(
    parameter int ANGLE_FRAC_BITS = 24,
    parameter int OUT_FRAC_BITS   = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [sincos_pkg::ANGLE_W-1:0] s_angle,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [sincos_pkg::OUT_W-1:0]   m_sine_value,
    output logic signed [sincos_pkg::OUT_W-1:0]   m_cosine_value
);
    import sincos_pkg::*;

    logic    red_valid, red_ready;
    x_pair_t red_data;
    logic    poly_valid, poly_ready;
    y_pair_t poly_data;

    sincos_reduce #(
        .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_angle  (s_angle),
        .out_valid (red_valid),
        .out_ready (red_ready),
        .out_data  (red_data)
    );

    sincos_poly u_poly (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .in_data   (red_data),
        .out_valid (poly_valid),
        .out_ready (poly_ready),
        .out_data  (poly_data)
    );

    sincos_round #(
        .OUT_FRAC_BITS(OUT_FRAC_BITS)
    ) u_round (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (poly_valid),
        .in_ready   (poly_ready),
        .in_data    (poly_data),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_sine   (m_sine_value),
        .out_cosine (m_cosine_value)
    );

    `SCP_ASSERT_IMPL(a_empty_ready, aclk, aresetn, !m_valid, s_ready)

endmodule
